@@ hdl/rre_pkg.sv @@
// Shared types, constants and helper functions of the ripening rate estimator.
`default_nettype none
package rre_pkg;

	// Sample window
	localparam int WINDOW_DEPTH = 8;
	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	// Shared long divider geometry
	localparam int DIV_NUM_W = 61;
	localparam int DIV_DEN_W = 33;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] SLOPE_DIV_STEPS = 6'd17;
	localparam logic [DIV_CNT_W-1:0] RATE_DIV_STEPS = 6'd40;
	localparam logic [DIV_CNT_W-1:0] INV_DIV_STEPS = 6'd61;

	// Fixed-point constants
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic signed [32:0] GATE_PRODUCT = 33'sd4194304;
	localparam logic [15:0] GATE_SAMPLE = 16'd3277;
	localparam logic signed [41:0] E_ZERO_LIMIT = 42'sd268435456;
	localparam logic signed [41:0] E_FULL_LIMIT = -42'sd16777216;
	localparam logic [3:0] SERIES_TERMS = 4'd12;

	// Register reset values
	localparam logic [15:0] BASE_TEMP_RST = 16'd3200;
	localparam logic [15:0] IDEAL_TEMP_RST = 16'd5120;
	localparam logic [15:0] RATE_INIT_RST = 16'd5243;
	localparam logic [15:0] BLEND_W_RST = 16'd3277;
	localparam logic [15:0] RATE_FLOOR_RST = 16'd655;
	localparam logic [15:0] RATE_CEIL_RST = 16'd13107;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BASE_TEMP  = 3'd0,
		CFG_IDEAL_TEMP = 3'd1,
		CFG_RATE_INIT  = 3'd2,
		CFG_BLEND_W    = 3'd3,
		CFG_RATE_FLOOR = 3'd4,
		CFG_RATE_CEIL  = 3'd5
	} cfg_idx_t;

	// Datapath commands issued by the controller
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SLOPE_START,
		CMD_SLOPE_ZERO,
		CMD_SLOPE_SET,
		CMD_RATE_START,
		CMD_RATE_SET,
		CMD_BLEND_MUL,
		CMD_BLEND_ADD,
		CMD_E_MUL1,
		CMD_E_MUL2,
		CMD_T_MUL,
		CMD_T_SET,
		CMD_G_MUL,
		CMD_SER_MUL,
		CMD_SER_RECIP,
		CMD_SER_FIX,
		CMD_INV_START,
		CMD_REF_SET,
		CMD_REF_SAT,
		CMD_EMIT
	} cmd_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic div_done;
		logic fill_zero;
		logic gate_ok;
		logic blend_ok;
		logic e_sat;
		logic series_last;
		logic out_free;
	} dp_status_t;

	// floor(2^32 / k) for the series term division by k
	function automatic logic [32:0] recip_k(input logic [3:0] k);
		logic [32:0] r;
		case (k)
			4'd1:    r = 33'd4294967296;
			4'd2:    r = 33'd2147483648;
			4'd3:    r = 33'd1431655765;
			4'd4:    r = 33'd1073741824;
			4'd5:    r = 33'd858993459;
			4'd6:    r = 33'd715827882;
			4'd7:    r = 33'd613566756;
			4'd8:    r = 33'd536870912;
			4'd9:    r = 33'd477218588;
			4'd10:   r = 33'd429496729;
			4'd11:   r = 33'd390451572;
			4'd12:   r = 33'd357913941;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rre_div.sv @@
// Restoring long divider, one quotient bit per cycle.
`default_nettype none
module rre_div
	import rre_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	input  wire logic [DIV_CNT_W-1:0] steps,
	output logic                      done,
	output logic [DIV_NUM_W-1:0]      quot
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 fits;

	// Shift in the next numerator bit and try the subtraction.
	always_comb begin
		rem_sh = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
		fits = (rem_sh >= {1'b0, den_q});
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= steps;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (cnt_q != '0)
				cnt_q <= cnt_q - 6'd1;
		end
	end

	// Operands and partial results.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quot_q <= {quot_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ hdl/rre_datapath.sv @@
// Datapath: registers, sample ring, multipliers and the shared divider.
`default_nettype none
module rre_datapath
	import rre_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output dp_status_t       status,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic [15:0] color_index,
	input  wire logic [15:0] temperature,
	input  wire logic [7:0]  elapsed_days,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [15:0]      slope,
	output logic [15:0]      reference_index,
	output logic [15:0]      rate_estimate,
	output logic             rate_updated
);

	// Configuration and rate state
	logic [15:0] base_q, ideal_q, w_q, floor_q, ceil_q, rate_q;

	// Sample ring
	logic [15:0]       ring_mem [WINDOW_DEPTH];
	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_old_q;
	logic [PTR_W-1:0]  oldest;
	logic [15:0]       old_q;

	// Item and working registers
	logic [15:0]        x_q, temp_q;
	logic [7:0]         days_q;
	logic               upd_q;
	logic signed [15:0] slope_q;
	logic signed [32:0] prod_q;
	logic [17:0]        k_q;
	logic [32:0]        p1_q;
	logic signed [33:0] ed_q;
	logic signed [41:0] e_q;
	logic               eneg_q;
	logic [58:0]        tm_q;
	logic [4:0]         n_q;
	logic [23:0]        f_q;
	logic [29:0]        g_q;
	logic [30:0]        term_q;
	logic [31:0]        sum_q;
	logic [3:0]         kc_q;
	logic [59:0]        pm_q;
	logic [29:0]        a_q;
	logic [62:0]        rm_q;
	logic [15:0]        ref_q;

	// Output register
	logic        ov_q;
	logic [15:0] o_slope_q, o_ref_q, o_rate_q;
	logic        o_upd_q;

	// Combinational helpers
	logic signed [16:0] d, tdiff, dt;
	logic [16:0]        dmag;
	logic signed [33:0] prod_full, ed_full;
	logic signed [42:0] e_full;
	logic [41:0]        eabs;
	logic [16:0]        qmag;
	logic [15:0]        slope_new;
	logic [15:0]        neg_slope;
	logic [33:0]        acc;
	logic [28:0]        tsh, tval;
	logic [53:0]        fm;
	logic [29:0]        q0;
	logic [33:0]        q0k, rres;
	logic [29:0]        qq;
	logic [5:0]         sh;
	logic [30:0]        inv;
	logic [30:0]        inv_sh;
	logic [31:0]        rnd;
	logic [15:0]        ref_new;
	logic               e_zero, e_one;
	logic               div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_CNT_W-1:0] div_steps;

	assign oldest = (fill_q < FILL_W'(WINDOW_DEPTH)) ? '0 : wp_q;

	// Arithmetic of the current step
	always_comb begin
		d = $signed({1'b0, x_q}) - $signed({1'b0, old_q});
		dmag = d[16] ? 17'(-d) : 17'(d);
		tdiff = $signed({temp_q[15], temp_q}) - $signed({base_q[15], base_q});
		dt = $signed({ideal_q[15], ideal_q}) - $signed({base_q[15], base_q});
		prod_full = tdiff * $signed({1'b0, x_q});
		ed_full = $signed({1'b0, rate_q}) * dt;
		e_full = ed_q * $signed({1'b0, days_q});
		eabs = e_q[41] ? 42'(-e_q) : 42'(e_q);
		qmag = div_quot[16:0];
		// Saturate the truncated slope quotient to the signed 16-bit range.
		if (d[16])
			slope_new = (qmag > 17'd32768) ? 16'h8000 : 16'(-qmag);
		else
			slope_new = (qmag > 17'd32767) ? 16'h7FFF : qmag[15:0];
		neg_slope = 16'(-slope_q);
		acc = {1'b0, p1_q} + ({18'd0, w_q} * {18'd0, k_q[15:0]}) + 34'd32768;
		tsh = tm_q[58:30];
		tval = eneg_q ? (29'd33554432 - tsh) : (tsh + 29'd33554432);
		fm = f_q * LN2_Q30;
		q0 = rm_q[61:32];
		q0k = {4'd0, q0} * {30'd0, kc_q};
		rres = {4'd0, a_q} - q0k;
		qq = (rres >= {30'd0, kc_q}) ? (q0 + 30'd1) : q0;
		sh = 6'd13 + {1'b0, n_q};
		inv = div_quot[30:0];
		inv_sh = inv >> (sh - 6'd1);
		rnd = ({1'b0, inv_sh} + 32'd1) >> 1;
		if (sh >= 6'd40)
			ref_new = '0;
		else if (rnd > 32'd65535)
			ref_new = 16'hFFFF;
		else
			ref_new = rnd[15:0];
		e_zero = (e_q >= E_ZERO_LIMIT);
		e_one = (e_q <= E_FULL_LIMIT);
	end

	// Divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		div_steps = '0;
		case (cmd)
			CMD_SLOPE_START: begin
				div_start = 1'b1;
				div_num = {dmag, 44'd0};
				div_den = DIV_DEN_W'(fill_old_q);
				div_steps = SLOPE_DIV_STEPS;
			end
			CMD_RATE_START: begin
				div_start = 1'b1;
				div_num = {neg_slope, 45'd0};
				div_den = prod_q[32:0];
				div_steps = RATE_DIV_STEPS;
			end
			CMD_INV_START: begin
				div_start = 1'b1;
				div_num = {1'b1, 60'd0} + {29'd0, sum_q[31:1]};
				div_den = {1'b0, sum_q};
				div_steps = INV_DIV_STEPS;
			end
			default: begin
			end
		endcase
	end

	rre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Configuration registers and the rate estimate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_TEMP_RST;
			ideal_q <= IDEAL_TEMP_RST;
			w_q <= BLEND_W_RST;
			floor_q <= RATE_FLOOR_RST;
			ceil_q <= RATE_CEIL_RST;
			rate_q <= RATE_INIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_BASE_TEMP:  base_q <= cfg_data;
				CFG_IDEAL_TEMP: ideal_q <= cfg_data;
				CFG_RATE_INIT:  rate_q <= cfg_data;
				CFG_BLEND_W:    w_q <= cfg_data;
				CFG_RATE_FLOOR: floor_q <= cfg_data;
				CFG_RATE_CEIL:  ceil_q <= cfg_data;
				default: begin
				end
			endcase
		end else if (cmd == CMD_BLEND_ADD) begin
			rate_q <= acc[31:16];
		end
	end

	// Ring pointer, fill count and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cmd == CMD_LOAD) begin
				wp_q <= (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
				if (fill_q < FILL_W'(WINDOW_DEPTH))
					fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd == CMD_EMIT)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	// Sample ring: read the oldest slot while the new sample is written.
	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			ring_mem[wp_q] <= color_index;
			old_q <= ring_mem[oldest];
		end
	end

	// Working registers, one step per command.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				x_q <= color_index;
				temp_q <= temperature;
				days_q <= elapsed_days;
				fill_old_q <= fill_q;
				upd_q <= 1'b0;
			end
			CMD_SLOPE_START: prod_q <= prod_full[32:0];
			CMD_SLOPE_ZERO: begin
				prod_q <= prod_full[32:0];
				slope_q <= '0;
			end
			CMD_SLOPE_SET: slope_q <= slope_new;
			CMD_RATE_SET:  k_q <= div_quot[17:0];
			CMD_BLEND_MUL: p1_q <= {16'd0, 17'd65536 - {1'b0, w_q}} * {17'd0, rate_q};
			CMD_BLEND_ADD: upd_q <= 1'b1;
			CMD_E_MUL1:    ed_q <= ed_full;
			CMD_E_MUL2:    e_q <= e_full[41:0];
			CMD_T_MUL: begin
				tm_q <= eabs[27:0] * LOG2E_Q30;
				eneg_q <= e_q[41];
			end
			CMD_T_SET: begin
				n_q <= tval[28:24];
				f_q <= tval[23:0];
			end
			CMD_G_MUL: begin
				g_q <= fm[53:24];
				term_q <= 31'd1073741824;
				sum_q <= 32'd1073741824;
				kc_q <= 4'd1;
			end
			CMD_SER_MUL:   pm_q <= {29'd0, term_q} * {30'd0, g_q};
			CMD_SER_RECIP: begin
				a_q <= pm_q[59:30];
				rm_q <= pm_q[59:30] * recip_k(kc_q);
			end
			CMD_SER_FIX: begin
				term_q <= {1'b0, qq};
				sum_q <= sum_q + {2'd0, qq};
				kc_q <= kc_q + 4'd1;
			end
			CMD_REF_SET: ref_q <= ref_new;
			CMD_REF_SAT: ref_q <= e_zero ? 16'd0 : 16'hFFFF;
			CMD_EMIT: begin
				o_slope_q <= slope_q;
				o_ref_q <= ref_q;
				o_rate_q <= rate_q;
				o_upd_q <= upd_q;
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller
	always_comb begin
		status.div_done = div_done;
		status.fill_zero = (fill_old_q == '0);
		status.gate_ok = (prod_q > GATE_PRODUCT) && (x_q >= GATE_SAMPLE) && slope_q[15];
		status.blend_ok = (k_q > {2'd0, floor_q}) && (k_q < {2'd0, ceil_q});
		status.e_sat = e_zero || e_one;
		status.series_last = (kc_q == SERIES_TERMS);
		status.out_free = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign slope = o_slope_q;
	assign reference_index = o_ref_q;
	assign rate_estimate = o_rate_q;
	assign rate_updated = o_upd_q;

endmodule
`default_nettype wire

@@ hdl/rre_ctrl.sv @@
// Controller state machine that sequences the datapath for one request.
`default_nettype none
module rre_ctrl
	import rre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output cmd_t            cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SLOPE,
		ST_SLOPE_WAIT,
		ST_GATE,
		ST_RATE_WAIT,
		ST_BLEND_CHK,
		ST_BLEND_ADD,
		ST_E1,
		ST_E2,
		ST_E_CHK,
		ST_T_SET,
		ST_G,
		ST_SER_MUL,
		ST_SER_RECIP,
		ST_SER_FIX,
		ST_INV,
		ST_INV_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;

	// Next state and the command for this cycle.
	always_comb begin
		state_d = state_q;
		cmd = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd = CMD_LOAD;
					state_d = ST_SLOPE;
				end
			end
			ST_SLOPE: begin
				if (status.fill_zero) begin
					cmd = CMD_SLOPE_ZERO;
					state_d = ST_GATE;
				end else begin
					cmd = CMD_SLOPE_START;
					state_d = ST_SLOPE_WAIT;
				end
			end
			ST_SLOPE_WAIT: begin
				if (status.div_done) begin
					cmd = CMD_SLOPE_SET;
					state_d = ST_GATE;
				end
			end
			ST_GATE: begin
				if (status.gate_ok) begin
					cmd = CMD_RATE_START;
					state_d = ST_RATE_WAIT;
				end else begin
					cmd = CMD_E_MUL1;
					state_d = ST_E2;
				end
			end
			ST_RATE_WAIT: begin
				if (status.div_done) begin
					cmd = CMD_RATE_SET;
					state_d = ST_BLEND_CHK;
				end
			end
			ST_BLEND_CHK: begin
				if (status.blend_ok) begin
					cmd = CMD_BLEND_MUL;
					state_d = ST_BLEND_ADD;
				end else begin
					cmd = CMD_E_MUL1;
					state_d = ST_E2;
				end
			end
			ST_BLEND_ADD: begin
				cmd = CMD_BLEND_ADD;
				state_d = ST_E1;
			end
			ST_E1: begin
				cmd = CMD_E_MUL1;
				state_d = ST_E2;
			end
			ST_E2: begin
				cmd = CMD_E_MUL2;
				state_d = ST_E_CHK;
			end
			ST_E_CHK: begin
				if (status.e_sat) begin
					cmd = CMD_REF_SAT;
					state_d = ST_EMIT;
				end else begin
					cmd = CMD_T_MUL;
					state_d = ST_T_SET;
				end
			end
			ST_T_SET: begin
				cmd = CMD_T_SET;
				state_d = ST_G;
			end
			ST_G: begin
				cmd = CMD_G_MUL;
				state_d = ST_SER_MUL;
			end
			ST_SER_MUL: begin
				cmd = CMD_SER_MUL;
				state_d = ST_SER_RECIP;
			end
			ST_SER_RECIP: begin
				cmd = CMD_SER_RECIP;
				state_d = ST_SER_FIX;
			end
			ST_SER_FIX: begin
				cmd = CMD_SER_FIX;
				state_d = status.series_last ? ST_INV : ST_SER_MUL;
			end
			ST_INV: begin
				cmd = CMD_INV_START;
				state_d = ST_INV_WAIT;
			end
			ST_INV_WAIT: begin
				if (status.div_done) begin
					cmd = CMD_REF_SET;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd = CMD_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/ripening_rate_estimator_unit.sv @@
// The time from the accepting edge to m_tvalid is shortest when the curve saturates on a first
// sample and longest with the slope, rate and reciprocal divisions, which run one after another
// on the one shared divider, and a 12-term series.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (arst_n low) clears the controller, ring pointer, fill count and output valid, and
// loads the configuration registers and the rate estimate with their reset values.
`default_nettype none
module ripening_rate_estimator_unit
	import rre_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// color_index [15:0], temperature [31:16], elapsed_days [39:32]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// slope [15:0], reference_index [31:16], rate_estimate [47:32]
	output logic [47:0]      m_tdata,
	// rate_updated [0]
	output logic [0:0]       m_tuser,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cmd_t        cmd;
	dp_status_t  status;
	logic [15:0] slope, reference_index, rate_estimate;
	logic        rate_updated;

	rre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rre_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.color_index     (s_tdata[15:0]),
		.temperature     (s_tdata[31:16]),
		.elapsed_days    (s_tdata[39:32]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.slope           (slope),
		.reference_index (reference_index),
		.rate_estimate   (rate_estimate),
		.rate_updated    (rate_updated)
	);

	assign m_tdata = {rate_estimate, reference_index, slope};
	assign m_tuser = rate_updated;

endmodule
`default_nettype wire

@@ hdl/rre_checker.sv @@
// Port-level checks of the ripening rate estimator, bound to the top level.
`default_nettype none
module rre_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A request is worked on alone: no new request right after one is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted again right after a request");

	// A result cannot appear in the cycle after its request was taken.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// Registering a result frees the input side at once.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready when a result was registered");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind ripening_rate_estimator_unit rre_checker u_rre_checker (.*);
`default_nettype wire

@@ tb/sv/tb_ripening_rate_estimator_unit.sv @@
// Self-checking testbench of the ripening rate estimator: directed table, a saturating curve, then random samples.
`timescale 1ns / 1ps
`default_nettype none
module tb_ripening_rate_estimator_unit
	import rre_pkg::*;
();

	// Clock and reset
	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_wen;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	ripening_rate_estimator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One result of the estimator
	typedef struct packed {
		logic [15:0] slope;
		logic [15:0] ref_index;
		logic [15:0] rate;
		logic        updated;
	} estimate_t;

	// Directed row; has_ref/ref_val mark a reference value typed in by hand
	typedef struct {
		logic [15:0] color;
		logic [15:0] temp;
		logic [7:0]  days;
		logic        has_ref;
		logic [15:0] ref_val;
	} row_t;

	// Predictor state
	logic [15:0] ring_q[WINDOW_DEPTH];
	int unsigned wr_ptr, fill;
	longint unsigned rate_val;
	longint base_t, ideal_t;
	longint unsigned w_blend, r_floor, r_ceil;

	estimate_t expected_q[$];
	logic [15:0] typed_ref_q[$];
	logic typed_has_q[$];
	int errors;
	int idle_cycles;
	bit long_hold;

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	// 2^(-t/2^24) * 2^17, rounded and saturated
	function automatic longint unsigned pow2_neg(longint unsigned t);
		longint unsigned n, f, g, term, sum, inv, r, sh;
		n = t >> 24;
		f = t & 64'hFFFFFF;
		g = (f * 64'd744261118) >> 24;
		term = 64'd1 << 30;
		sum = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = (term * g) / (longint'(k) << 30);
			sum += term;
		end
		inv = ((64'd1 << 60) + sum / 2) / sum;
		sh = 13 + n;
		if (sh >= 40) return 0;
		r = (inv + (64'd1 << (sh - 1))) >> sh;
		return (r > 65535) ? 65535 : r;
	endfunction

	function automatic logic [15:0] decay_curve(logic [7:0] days);
		longint e;
		longint unsigned t, ue;
		e = longint'(rate_val) * (ideal_t - base_t) * longint'(days);
		if (e >= (64'sd16 << 24)) return 16'd0;
		if (e <= -(64'sd1 << 24)) return 16'hFFFF;
		if (e >= 0) begin
			ue = e;
			t = ((ue * 64'd1549082005) >> 30) + (64'd2 << 24);
		end else begin
			ue = -e;
			t = (64'd2 << 24) - ((ue * 64'd1549082005) >> 30);
		end
		return 16'(pow2_neg(t));
	endfunction

	// Advance the predictor by one sample and return its result
	function automatic estimate_t predict_estimate(logic [39:0] d);
		estimate_t res;
		longint x, temp, prod, dd, q, slope;
		longint unsigned k, acc;
		int unsigned oldest;
		x = longint'(d[15:0]);
		temp = sx16(d[31:16]);
		slope = 0;
		res.updated = 1'b0;
		if (fill > 0) begin
			oldest = (fill < WINDOW_DEPTH) ? 0 : wr_ptr;
			dd = x - longint'(ring_q[oldest]);
			q = dd / longint'(fill);
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			slope = q;
		end
		ring_q[wr_ptr] = d[15:0];
		wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
		if (fill < WINDOW_DEPTH) fill++;
		prod = (temp - base_t) * x;
		if (prod > (64'sd1 << 22) && x >= 3277 && slope < 0) begin
			k = ((-slope) << 24) / prod;
			if (k > r_floor && k < r_ceil) begin
				acc = (65536 - w_blend) * rate_val + w_blend * k + 32768;
				rate_val = (acc >> 16) & 64'hFFFF;
				res.updated = 1'b1;
			end
		end
		res.slope = 16'(slope);
		res.ref_index = decay_curve(d[39:32]);
		res.rate = 16'(rate_val);
		return res;
	endfunction

	// Register write, mirrored in the predictor
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_BASE_TEMP:  base_t = sx16(val);
			CFG_IDEAL_TEMP: ideal_t = sx16(val);
			CFG_RATE_INIT:  rate_val = val;
			CFG_BLEND_W:    w_blend = val;
			CFG_RATE_FLOOR: r_floor = val;
			CFG_RATE_CEIL:  r_ceil = val;
			default: ;
		endcase
	endtask

	// Random gap, mostly short; the input goes idle only when there is a gap
	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one sample and record its prediction once accepted
	task automatic send_sample(logic [39:0] d, logic has_ref, logic [15:0] ref_val);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(predict_estimate(d));
		typed_has_q.push_back(has_ref);
		typed_ref_q.push_back(ref_val);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Receiver with random stalls and one long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 50) : 0) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		estimate_t exp_r;
		logic th;
		logic [15:0] tr;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h/%h", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				th = typed_has_q.pop_front();
				tr = typed_ref_q.pop_front();
				if (th && tr != m_tdata[31:16]) begin
					$display("%0t: typed reference exp %h got %h", $time, tr,
						m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[15:0] != exp_r.slope) begin
					$display("%0t: slope exp %h got %h", $time, exp_r.slope, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] != exp_r.ref_index) begin
					$display("%0t: reference exp %h got %h", $time, exp_r.ref_index,
						m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[47:32] != exp_r.rate) begin
					$display("%0t: rate exp %h got %h", $time, exp_r.rate, m_tdata[47:32]);
					errors++;
				end
				if (m_tuser[0] != exp_r.updated) begin
					$display("%0t: updated exp %b got %b", $time, exp_r.updated, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with neither an accepted request nor an accepted result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Random sample: mostly a decaying ripening run with warm temperatures
	function automatic logic [39:0] random_sample(ref int level);
		logic [15:0] c, t;
		logic [7:0] dy;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			level = level - $urandom_range(0, 400);
			if (level < 3277) level = $urandom_range(20000, 32768);
			c = 16'(level);
			t = 16'($urandom_range(3200, 21760));
			dy = 8'($urandom_range(0, 40));
		end else begin
			c = 16'($urandom());
			t = 16'($urandom());
			dy = 8'($urandom());
		end
		return {dy, t, c};
	endfunction

	initial begin
		row_t rows[$];
		int level;
		errors = 0;
		idle_cycles = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_index = CFG_BASE_TEMP;
		cfg_data = '0;
		wr_ptr = 0;
		fill = 0;
		foreach (ring_q[i]) ring_q[i] = '0;
		base_t = 3200; ideal_t = 5120; rate_val = 5243;
		w_blend = 3277; r_floor = 655; r_ceil = 13107;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: zero days gives the full curve 1.0 exactly
		rows = '{
			'{16'd32768, 16'sd5120, 8'd0, 1'b1, 16'd32768},
			'{16'd32000, 16'sd6000, 8'd3, 1'b0, 16'd0},
			'{16'd31000, 16'sd7000, 8'd5, 1'b0, 16'd0},
			'{16'd30000, 16'sd21760, 8'd7, 1'b0, 16'd0},
			'{16'd0, -16'sd10240, 8'd255, 1'b1, 16'd0},
			'{16'd3277, 16'sd21760, 8'd1, 1'b0, 16'd0},
			'{16'd3276, 16'sd21760, 8'd1, 1'b0, 16'd0},
			'{16'd29000, 16'sd8000, 8'd10, 1'b0, 16'd0},
			'{16'd28000, 16'sd8000, 8'd20, 1'b0, 16'd0},
			'{16'd27000, 16'sd8000, 8'd30, 1'b0, 16'd0},
			'{16'hFFFF, 16'h7FFF, 8'hFF, 1'b0, 16'd0},
			'{16'd0, 16'h8000, 8'd0, 1'b1, 16'd32768},
			'{16'd26000, 16'sd9000, 8'd2, 1'b0, 16'd0}
		};
		foreach (rows[i]) begin
			send_sample({rows[i].days, rows[i].temp, rows[i].color}, rows[i].has_ref,
				rows[i].ref_val);
			random_gap();
		end
		wait_drained();

		// Ideal below base makes the curve grow and saturate
		write_reg(CFG_IDEAL_TEMP, -16'sd10240);
		write_reg(CFG_BASE_TEMP, 16'sd21760);
		send_sample({8'd200, 16'sd0, 16'd20000}, 1'b1, 16'hFFFF);
		send_sample({8'd0, 16'sd0, 16'd20000}, 1'b1, 16'd32768);
		wait_drained();

		// Random phases over several settings, extremes among them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_BASE_TEMP, 16'sd3200);
					write_reg(CFG_IDEAL_TEMP, 16'sd5120);
					write_reg(CFG_RATE_INIT, 16'd5243);
					write_reg(CFG_BLEND_W, 16'd3277);
					write_reg(CFG_RATE_FLOOR, 16'd655);
					write_reg(CFG_RATE_CEIL, 16'd13107);
				end
				1: begin
					write_reg(CFG_BLEND_W, 16'hFFFF);
					write_reg(CFG_RATE_FLOOR, 16'd0);
					write_reg(CFG_RATE_CEIL, 16'hFFFF);
					write_reg(CFG_RATE_INIT, 16'd0);
				end
				2: begin
					write_reg(CFG_BLEND_W, 16'd0);
					write_reg(CFG_RATE_INIT, 16'hFFFF);
					write_reg(CFG_BASE_TEMP, -16'sd10240);
					write_reg(CFG_IDEAL_TEMP, 16'sd21760);
				end
				default: begin
					write_reg(CFG_BASE_TEMP, 16'($urandom()));
					write_reg(CFG_IDEAL_TEMP, 16'($urandom()));
					write_reg(CFG_RATE_INIT, 16'($urandom()));
					write_reg(CFG_BLEND_W, 16'($urandom()));
					write_reg(CFG_RATE_FLOOR, 16'($urandom_range(0, 2000)));
					write_reg(CFG_RATE_CEIL, 16'($urandom_range(2000, 65535)));
				end
			endcase
			level = 32768;
			for (int i = 0; i < 400; i++) begin
				if (ph == 0 && i == 100) long_hold = 1'b1;
				send_sample(random_sample(level), 1'b0, 16'd0);
				if (!(ph == 0 && i >= 100 && i < 110)) random_gap();
			end
			wait_drained();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

@@ ripening_rate_estimator_unit.f @@
hdl/rre_pkg.sv
hdl/rre_div.sv
hdl/rre_datapath.sv
hdl/rre_ctrl.sv
hdl/ripening_rate_estimator_unit.sv
hdl/rre_checker.sv
tb/sv/tb_ripening_rate_estimator_unit.sv
